// ===== hw/rtl/circle_path_rasterizer_assert.svh =====
// ----------------------------------------------------------------
// circle_path_rasterizer_assert.svh
// assertion macros for the circle path rasterizer checkers
// ----------------------------------------------------------------
`ifndef CIRCLE_PATH_RASTERIZER_ASSERT_SVH
`define CIRCLE_PATH_RASTERIZER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define CPR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define CPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cpr_pkg.sv =====
// ----------------------------------------------------------------
// cpr_pkg
// shared widths, defaults and types of the circle path rasterizer
// ----------------------------------------------------------------
package cpr_pkg;

	localparam int COORD_W        = 16;
	localparam int RADIUS_W       = 5;
	localparam int IDX_W          = 6;
	localparam int OFS_W          = 6;
	localparam int MAX_RADIUS_DEF = 31;
	localparam int Q_DEPTH        = 2;

	// one circle request after classification
	typedef struct packed {
		logic [COORD_W-1:0]  cx;
		logic [COORD_W-1:0]  cy;
		logic [RADIUS_W-1:0] r;
	} job_t;

	// queue status seen by the walker
	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

endpackage

// ===== hw/rtl/cpr_front.sv =====
// ----------------------------------------------------------------
// cpr_front
// accepts circle requests, clamps the radius and hands jobs to the queue
// ----------------------------------------------------------------
module cpr_front #(
	parameter int MAX_RADIUS = cpr_pkg::MAX_RADIUS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [cpr_pkg::COORD_W-1:0]  center_x,
	input  logic [cpr_pkg::COORD_W-1:0]  center_y,
	input  logic [cpr_pkg::RADIUS_W-1:0] radius,
	input  cpr_pkg::q_stat_t             q_stat,
	output logic                         push,
	output cpr_pkg::job_t                push_job
);

	localparam logic [cpr_pkg::RADIUS_W-1:0] R_MAX = cpr_pkg::RADIUS_W'(MAX_RADIUS);

	logic          fr_valid_s1;
	cpr_pkg::job_t fr_job_s1;
	logic          accept;

	// hand off whenever the queue has room
	assign push     = fr_valid_s1 && !q_stat.full;
	assign push_job = fr_job_s1;
	assign busy     = fr_valid_s1 && q_stat.full;
	assign accept   = start && !busy;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_s1 <= 1'b0;
		end else if (accept) begin
			fr_valid_s1 <= 1'b1;
		end else if (push) begin
			fr_valid_s1 <= 1'b0;
		end
	end

	// capture beat, clamp radius
	always_ff @(posedge clk) begin
		if (accept) begin
			fr_job_s1.cx <= center_x;
			fr_job_s1.cy <= center_y;
			fr_job_s1.r  <= (radius > R_MAX) ? R_MAX : radius;
		end
	end

endmodule

// ===== hw/rtl/cpr_queue.sv =====
// ----------------------------------------------------------------
// cpr_queue
// short job queue between the front and the walker
// ----------------------------------------------------------------
module cpr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cpr_pkg::job_t    push_job,
	input  logic             pop,
	output cpr_pkg::job_t    head_job,
	output cpr_pkg::q_stat_t q_stat
);

	localparam int DEPTH = cpr_pkg::Q_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	cpr_pkg::job_t  slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign q_stat.not_empty = (count_q != '0);
	assign q_stat.full      = (count_q == CW'(DEPTH));
	assign do_push          = push && !q_stat.full;
	assign do_pop           = pop && q_stat.not_empty;
	assign head_job         = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== hw/rtl/cpr_walk.sv =====
// ----------------------------------------------------------------
// cpr_walk
// walks one quadrant a point per cycle and drives the mirrored results
// ----------------------------------------------------------------
module cpr_walk #(
	parameter int MAX_RADIUS = cpr_pkg::MAX_RADIUS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cpr_pkg::job_t               head_job,
	input  cpr_pkg::q_stat_t            q_stat,
	output logic                        pop,
	output logic                        strobe,
	output logic [cpr_pkg::IDX_W-1:0]   point_index,
	output logic [cpr_pkg::COORD_W-1:0] first_x,
	output logic [cpr_pkg::COORD_W-1:0] first_y,
	output logic [cpr_pkg::COORD_W-1:0] second_x,
	output logic [cpr_pkg::COORD_W-1:0] second_y,
	output logic [cpr_pkg::COORD_W-1:0] third_x,
	output logic [cpr_pkg::COORD_W-1:0] third_y,
	output logic [cpr_pkg::COORD_W-1:0] fourth_x,
	output logic [cpr_pkg::COORD_W-1:0] fourth_y,
	output logic                        last_point
);

	localparam int OW = cpr_pkg::OFS_W;
	localparam int SW = 2 * OW + 1;
	localparam int CW = cpr_pkg::COORD_W;
	localparam logic [cpr_pkg::IDX_W-1:0] LAST_IDX = cpr_pkg::IDX_W'(2 * MAX_RADIUS);

	logic                        active_q;
	logic [OW-1:0]               x_q;
	logic [OW-1:0]               y_q;
	logic [cpr_pkg::IDX_W-1:0]   idx_q;
	logic [SW-1:0]               rr_q;
	logic [CW-1:0]               cx_q;
	logic [CW-1:0]               cy_q;

	logic [OW-1:0]               xp1;
	logic [OW-1:0]               ym1;
	logic [2*OW-1:0]             sq_x;
	logic [2*OW-1:0]             sq_y;
	logic [2*OW-1:0]             sq_ym;
	logic                        go_right;
	logic                        go_diag;
	logic                        last_now;
	logic [CW-1:0]               ox;
	logic [CW-1:0]               oy;

	// step candidates
	assign xp1      = x_q + 1'b1;
	assign ym1      = y_q - 1'b1;
	assign sq_x     = xp1 * xp1;
	assign sq_y     = y_q * y_q;
	assign sq_ym    = ym1 * ym1;
	assign go_right = (SW'(sq_x) + SW'(sq_y)) <= rr_q;
	assign go_diag  = (SW'(sq_x) + SW'(sq_ym)) <= rr_q;

	// run ends at the axis or at the walk length guard
	assign last_now = active_q && ((y_q == '0) || (idx_q == LAST_IDX));
	assign pop      = q_stat.not_empty && (!active_q || last_now);

	assign ox = CW'(x_q);
	assign oy = CW'(y_q);

	// walker position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (pop) begin
			active_q <= 1'b1;
		end else if (last_now) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q   <= '0;
			y_q   <= OW'(head_job.r);
			idx_q <= '0;
			rr_q  <= SW'(head_job.r) * SW'(head_job.r);
			cx_q  <= head_job.cx;
			cy_q  <= head_job.cy;
		end else if (active_q) begin
			idx_q <= idx_q + 1'b1;
			if (go_right) begin
				x_q <= xp1;
			end else if (go_diag) begin
				x_q <= xp1;
				y_q <= ym1;
			end else begin
				y_q <= ym1;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= active_q;
		end
	end

	// result beat with the four mirrors
	always_ff @(posedge clk) begin
		if (active_q) begin
			point_index <= idx_q;
			first_x     <= cx_q + ox;
			first_y     <= cy_q + oy;
			second_x    <= cx_q + ox;
			second_y    <= cy_q - oy;
			third_x     <= cx_q - ox;
			third_y     <= cy_q - oy;
			fourth_x    <= cx_q - ox;
			fourth_y    <= cy_q + oy;
			last_point  <= last_now;
		end
	end

endmodule

// ===== hw/rtl/circle_path_rasterizer.sv =====
// ----------------------------------------------------------------
// circle_path_rasterizer
// quadrant walk of a circle with its four mirrored points per beat
// ----------------------------------------------------------------
// Usage:
//   A request (center_x, center_y, radius) is taken on a clock edge with
//   start high and busy low. Radii above MAX_RADIUS are clamped; radius 0
//   gives one point at the center.
//   Each point beat shows for one cycle with strobe high: point_index, the
//   four mirrored coordinates, and last_point on the final beat of a run.
//   A run of radius r gives at most 2r+1 beats, one per cycle, set by the
//   single step unit of the walker.
//   A request passes the front register, the two-entry job queue, the
//   walker and the output register before its first beat appears.
//   Runs follow each other with no idle cycle; busy rises only while the
//   front stage holds a job and the queue is full.
//   Reset clears the front stage, the queue and the walker; no beat is
//   shown until a new request arrives. The receiver cannot stall: every
//   strobe beat is final.
// ----------------------------------------------------------------
module circle_path_rasterizer #(
	parameter int MAX_RADIUS = cpr_pkg::MAX_RADIUS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [cpr_pkg::COORD_W-1:0]  center_x,
	input  logic signed [cpr_pkg::COORD_W-1:0]  center_y,
	input  logic        [cpr_pkg::RADIUS_W-1:0] radius,
	output logic                                strobe,
	output logic        [cpr_pkg::IDX_W-1:0]    point_index,
	output logic signed [cpr_pkg::COORD_W-1:0]  first_x,
	output logic signed [cpr_pkg::COORD_W-1:0]  first_y,
	output logic signed [cpr_pkg::COORD_W-1:0]  second_x,
	output logic signed [cpr_pkg::COORD_W-1:0]  second_y,
	output logic signed [cpr_pkg::COORD_W-1:0]  third_x,
	output logic signed [cpr_pkg::COORD_W-1:0]  third_y,
	output logic signed [cpr_pkg::COORD_W-1:0]  fourth_x,
	output logic signed [cpr_pkg::COORD_W-1:0]  fourth_y,
	output logic                                last_point
);

	logic             push;
	logic             pop;
	cpr_pkg::job_t    push_job;
	cpr_pkg::job_t    head_job;
	cpr_pkg::q_stat_t q_stat;

	// request intake
	cpr_front #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	// job queue
	cpr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.q_stat   (q_stat)
	);

	// quadrant walker
	cpr_walk #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_job    (head_job),
		.q_stat      (q_stat),
		.pop         (pop),
		.strobe      (strobe),
		.point_index (point_index),
		.first_x     (first_x),
		.first_y     (first_y),
		.second_x    (second_x),
		.second_y    (second_y),
		.third_x     (third_x),
		.third_y     (third_y),
		.fourth_x    (fourth_x),
		.fourth_y    (fourth_y),
		.last_point  (last_point)
	);

endmodule

// ===== hw/rtl/cpr_checker.sv =====
// ----------------------------------------------------------------
// cpr_checker
// port-level checks of the rasterizer result stream
// ----------------------------------------------------------------
`include "circle_path_rasterizer_assert.svh"

module cpr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                strobe,
	input logic        [cpr_pkg::IDX_W-1:0]    point_index,
	input logic signed [cpr_pkg::COORD_W-1:0]  first_x,
	input logic signed [cpr_pkg::COORD_W-1:0]  first_y,
	input logic signed [cpr_pkg::COORD_W-1:0]  second_x,
	input logic signed [cpr_pkg::COORD_W-1:0]  second_y,
	input logic signed [cpr_pkg::COORD_W-1:0]  third_x,
	input logic signed [cpr_pkg::COORD_W-1:0]  third_y,
	input logic signed [cpr_pkg::COORD_W-1:0]  fourth_x,
	input logic signed [cpr_pkg::COORD_W-1:0]  fourth_y,
	input logic                                last_point
);

	// a run continues every cycle with the next index
	`CPR_ASSERT_NEXT(a_run_contiguous, strobe && !last_point, strobe && (point_index == ($past(point_index) + 1'b1)), "run broke or index skipped")

	// after a last beat, only a fresh run may follow
	`CPR_ASSERT_NEXT(a_new_run_from_zero, strobe && last_point, !strobe || (point_index == '0), "new run did not start at index zero")

	// mirror pairs share their axis coordinate
	`CPR_ASSERT_NOW(a_mirror_pairs, strobe, (first_x == second_x) && (third_x == fourth_x) && (first_y == fourth_y) && (second_y == third_y), "mirror coordinates disagree")

endmodule

bind circle_path_rasterizer cpr_checker u_cpr_checker (.*);

// ===== tb/circle_path_rasterizer_tb.sv =====
// ----------------------------------------------------------------
// circle_path_rasterizer_tb
// self-checking bench for the circle quadrant walker
//
// Sends circle requests through the start/busy handshake and predicts
// every point beat from its own walk of the quadrant. Each strobe beat
// is checked field by field against the oldest predicted point. The
// requests cover small and zero radii, coordinate wraparound at the
// edges of the 16-bit range, and random traffic with and without gaps.
// ----------------------------------------------------------------
module circle_path_rasterizer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W     = cpr_pkg::COORD_W;
	localparam int RADIUS_W    = cpr_pkg::RADIUS_W;
	localparam int IDX_W       = cpr_pkg::IDX_W;
	localparam int RAD_MAX     = cpr_pkg::MAX_RADIUS_DEF;
	localparam int WALK_LIMIT  = 2 * RAD_MAX + 1;
	localparam int MAX_GAP     = 40;
	localparam int TAIL_CYCLES = 16;
	localparam int STALL_LIMIT = 2000;

	// one point beat: quadrant point and its three mirrors
	typedef struct packed {
		logic [IDX_W-1:0]   index;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] y2;
		logic [COORD_W-1:0] x3;
		logic [COORD_W-1:0] y3;
		logic [COORD_W-1:0] x4;
		logic [COORD_W-1:0] y4;
		logic               last;
	} mirror_point_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic signed [COORD_W-1:0]  center_x;
	logic signed [COORD_W-1:0]  center_y;
	logic        [RADIUS_W-1:0] radius;
	logic                       strobe;
	logic        [IDX_W-1:0]    point_index;
	logic signed [COORD_W-1:0]  first_x;
	logic signed [COORD_W-1:0]  first_y;
	logic signed [COORD_W-1:0]  second_x;
	logic signed [COORD_W-1:0]  second_y;
	logic signed [COORD_W-1:0]  third_x;
	logic signed [COORD_W-1:0]  third_y;
	logic signed [COORD_W-1:0]  fourth_x;
	logic signed [COORD_W-1:0]  fourth_y;
	logic                       last_point;

	mirror_point_t pending_points[$];
	int            error_count = 0;

	circle_path_rasterizer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.strobe      (strobe),
		.point_index (point_index),
		.first_x     (first_x),
		.first_y     (first_y),
		.second_x    (second_x),
		.second_y    (second_y),
		.third_x     (third_x),
		.third_y     (third_y),
		.fourth_x    (fourth_x),
		.fourth_y    (fourth_y),
		.last_point  (last_point)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// add one offset point with its mirrors to the expected beats
	function automatic void queue_point(input int idx, input logic [COORD_W-1:0] cx,
			input logic [COORD_W-1:0] cy, input int ox, input int oy, input bit last);
		mirror_point_t p;
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		dx = ox[COORD_W-1:0];
		dy = oy[COORD_W-1:0];
		p.index = idx[IDX_W-1:0];
		p.x1 = cx + dx;
		p.y1 = cy + dy;
		p.x2 = cx + dx;
		p.y2 = cy - dy;
		p.x3 = cx - dx;
		p.y3 = cy - dy;
		p.x4 = cx - dx;
		p.y4 = cy + dy;
		p.last = last;
		pending_points.push_back(p);
	endfunction

	// walk one quadrant from (0,r) and queue every point it visits
	function automatic void walk_quadrant(input logic [COORD_W-1:0] cx,
			input logic [COORD_W-1:0] cy, input logic [RADIUS_W-1:0] rad);
		int r;
		int x;
		int y;
		int rr;
		int count;
		bit last;
		r = rad;
		if (r > RAD_MAX)
			r = RAD_MAX;
		// zero radius: the center alone, flagged as last
		if (r == 0) begin
			queue_point(0, cx, cy, 0, 0, 1'b1);
			return;
		end
		x = 0;
		y = r;
		rr = r * r;
		count = 0;
		queue_point(count, cx, cy, x, y, 1'b0);
		count++;
		last = 1'b0;
		while (!last) begin
			if ((x + 1) * (x + 1) + y * y <= rr) begin
				x++;
			end else if ((x + 1) * (x + 1) + (y - 1) * (y - 1) <= rr) begin
				x++;
				y--;
			end else begin
				y--;
			end
			last = (y <= 0) || (count + 1 >= WALK_LIMIT);
			queue_point(count, cx, cy, x, y, last);
			count++;
		end
	endfunction

	// report one differing field, return 1 on mismatch
	function automatic int field_differs(input string name, input logic [IDX_W-1:0] idx,
			input logic [COORD_W-1:0] want, input logic [COORD_W-1:0] got);
		if (got === want)
			return 0;
		$display("%0t: point %0d %s expected %h actual %h", $time, idx, name, want, got);
		return 1;
	endfunction

	// check every strobe beat against the oldest expected point
	always @(posedge clk) begin : point_checker
		mirror_point_t want;
		if (arst_n === 1'b1 && strobe !== 1'b0) begin
			if (strobe !== 1'b1) begin
				$display("%0t: strobe expected 1 or 0 actual %b", $time, strobe);
				error_count++;
			end else if (pending_points.size() == 0) begin
				$display("%0t: beat expected none actual index %0d", $time, point_index);
				error_count++;
			end else begin
				want = pending_points.pop_front();
				error_count += field_differs("point_index", want.index,
					COORD_W'(want.index), COORD_W'(point_index));
				error_count += field_differs("first_x", want.index, want.x1, first_x);
				error_count += field_differs("first_y", want.index, want.y1, first_y);
				error_count += field_differs("second_x", want.index, want.x2, second_x);
				error_count += field_differs("second_y", want.index, want.y2, second_y);
				error_count += field_differs("third_x", want.index, want.x3, third_x);
				error_count += field_differs("third_y", want.index, want.y3, third_y);
				error_count += field_differs("fourth_x", want.index, want.x4, fourth_x);
				error_count += field_differs("fourth_y", want.index, want.y4, fourth_y);
				error_count += field_differs("last_point", want.index,
					COORD_W'(want.last), COORD_W'(last_point));
			end
		end
	end

	// end the run after a long stretch with no beat moving either way
	initial begin : stall_watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start === 1'b1 && busy === 1'b0) || strobe === 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("circle_path_rasterizer verification failed");
		$finish;
	end

	// one request beat, after a random gap; start stays high afterwards
	task automatic send_circle(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
			input logic [RADIUS_W-1:0] rad, input int idle_pct);
		int gap;
		gap = 0;
		while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		center_x <= cx;
		center_y <= cy;
		radius   <= rad;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		walk_quadrant(cx, cy, rad);
	endtask

	// hold off until every expected beat has come
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
	endtask

	// centers spread over the range, often close to the wrap points
	function automatic logic [COORD_W-1:0] pick_center();
		int sel;
		sel = $urandom_range(9);
		if (sel < 6)
			return COORD_W'($urandom);
		else if (sel < 8)
			return 16'h7FFF - COORD_W'($urandom_range(40));
		else
			return 16'h8000 + COORD_W'($urandom_range(40));
	endfunction

	// radii: some zero, many small, some at the maximum
	function automatic logic [RADIUS_W-1:0] pick_radius();
		int sel;
		sel = $urandom_range(99);
		if (sel < 5)
			return '0;
		else if (sel < 30)
			return RADIUS_W'($urandom_range(1, 4));
		else if (sel < 40)
			return RADIUS_W'(RAD_MAX);
		else
			return RADIUS_W'($urandom_range(1, RAD_MAX));
	endfunction

	// zero and small radii around fixed centers
	task automatic test_small_radii();
		for (int r = 0; r <= 5; r++)
			send_circle(16'h0000, 16'h0000, RADIUS_W'(r), 0);
		send_circle(16'h1234, 16'hFEDC, 5'd0, 0);
	endtask

	// largest radius at the corners of the coordinate range, plus other radii and centers
	task automatic test_coordinate_extremes();
		send_circle(16'h7FFF, 16'h7FFF, 5'd31, 0);
		send_circle(16'h8000, 16'h8000, 5'd31, 0);
		send_circle(16'h7FFF, 16'h8000, 5'd31, 0);
		send_circle(16'h8000, 16'h7FFF, 5'd31, 0);
		send_circle(16'h0000, 16'h0000, 5'd31, 0);
		send_circle(16'hFFFF, 16'h0001, 5'd31, 0);
		send_circle(16'h8000, 16'h7FFF, 5'd1, 0);
		send_circle(16'h5555, 16'hAAAA, 5'd16, 0);
		send_circle(16'hAAAA, 16'h5555, 5'd15, 0);
		send_circle(16'h0020, 16'hFFE0, 5'd30, 0);
	endtask

	// requests with the block fully drained between them
	task automatic test_drain_between_runs(input int n);
		repeat (n) begin
			send_circle(pick_center(), pick_center(), pick_radius(), 0);
			wait_drained();
		end
	endtask

	// random requests with the given chance of an idle cycle
	task automatic test_random_traffic(input int n, input int idle_pct);
		repeat (n)
			send_circle(pick_center(), pick_center(), pick_radius(), idle_pct);
	endtask

	// reset, tests in turn, then the verdict
	initial begin
		arst_n   <= 1'b0;
		start    <= 1'b0;
		center_x <= '0;
		center_y <= '0;
		radius   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_radii();
		test_coordinate_extremes();
		test_drain_between_runs(8);
		test_random_traffic(100, 0);
		test_random_traffic(100, 86);
		test_random_traffic(90, 6);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_points.size() != 0) begin
			$display("%0t: beats expected %0d more actual none", $time, pending_points.size());
			error_count++;
		end
		if (error_count == 0)
			$display("circle_path_rasterizer verification clean");
		else
			$display("circle_path_rasterizer verification failed");
		$finish;
	end

endmodule
